/* sv/pcts_pkg.sv */
// Shared types and constants for the preamble correlation timing search unit.
package pcts_pkg;

    localparam int DEF_SAMPLE_DEPTH = 8192;
    localparam int DEF_REF_DEPTH    = 1024;
    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int FRAC_BITS        = 14;
    localparam int CFG_WIDTH        = 10;
    localparam int GUESS_WIDTH      = 13;
    localparam int ACC_WIDTH        = 26;
    localparam int BANK_MAX         = 16;

    typedef enum logic [1:0] {
        OP_LOAD_REF    = 2'd0,
        OP_LOAD_SAMPLE = 2'd1,
        OP_START       = 2'd2,
        OP_NONE        = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        REG_BANK_COUNT      = 3'd0,
        REG_SAMPLES_PER_BIT = 3'd1,
        REG_PREAMBLE_LENGTH = 3'd2,
        REG_SEARCH_LEFT     = 3'd3,
        REG_SEARCH_RIGHT    = 3'd4,
        REG_DOWNHILL_LIMIT  = 3'd5
    } reg_index_t;

    // controller to datapath
    typedef struct packed {
        logic load_ref;
        logic load_sample;
        logic init_search;   // clear peak, run counter, best position
        logic init_bank;     // previous value to zero, shift to -left
        logic init_corr;     // acc to zero, k to zero
        logic issue;         // issue read for current k, advance k
        logic accum;         // add returned read data
        logic evaluate;      // compare finished correlation
        logic next_shift;
        logic next_bank;
    } pcts_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic k_last;        // current k is the final position
        logic len_zero;
        logic shift_done;    // shift loop exhausted or abandoned
        logic bank_done;     // all banks searched
        logic none;          // nothing to search
    } pcts_status_t;

endpackage

/* sv/preamble_correlation_timing_search_unit.sv */
// Top level of the preamble correlation timing search unit.
// Load beats (reference bit, sample) are accepted one per cycle while idle with no result pending.
// A start beat searches bank_count*samples_per_bit phases, each factor saturated at 16,
// using one sample-memory read per reference position.
// Result is held in an output register until taken; next beat waits for it.
// Asynchronous active-low reset clears fills, peak tracking and control; memories are not cleared.
module preamble_correlation_timing_search_unit #(
    parameter int SAMPLE_DEPTH = pcts_pkg::DEF_SAMPLE_DEPTH,
    parameter int REF_DEPTH    = pcts_pkg::DEF_REF_DEPTH,
    parameter int SAMPLE_WIDTH = pcts_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [2:0]                         cfg_index,
    input  logic [pcts_pkg::CFG_WIDTH-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         opcode,
    input  logic                               ref_bit,
    input  logic signed [SAMPLE_WIDTH-1:0]     sample_value,
    input  logic [pcts_pkg::GUESS_WIDTH-1:0]   start_guess,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         peak_bank,
    output logic signed [8:0]                  best_shift,
    output logic signed [pcts_pkg::ACC_WIDTH-1:0] peak_value,
    output logic                               found
);
    import pcts_pkg::*;

    logic [4:0] bank_count_reg, spb_reg;
    logic [9:0] len_reg;
    logic [7:0] left_reg, right_reg, downhill_reg;
    pcts_cmd_t    cmd;
    pcts_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_count_reg <= 5'd4;
            spb_reg        <= 5'd4;
            len_reg        <= 10'd63;
            left_reg       <= 8'd100;
            right_reg      <= 8'd200;
            downhill_reg   <= 8'd56;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_BANK_COUNT:      bank_count_reg <= cfg_data[4:0];
                REG_SAMPLES_PER_BIT: spb_reg        <= cfg_data[4:0];
                REG_PREAMBLE_LENGTH: len_reg        <= cfg_data[9:0];
                REG_SEARCH_LEFT:     left_reg       <= cfg_data[7:0];
                REG_SEARCH_RIGHT:    right_reg      <= cfg_data[7:0];
                REG_DOWNHILL_LIMIT:  downhill_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    pcts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    pcts_datapath #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .REF_DEPTH    (REF_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .ref_bit         (ref_bit),
        .sample_value    (sample_value),
        .start_guess     (start_guess),
        .bank_count      (bank_count_reg),
        .samples_per_bit (spb_reg),
        .preamble_length (len_reg),
        .search_left     (left_reg),
        .search_right    (right_reg),
        .downhill_limit  (downhill_reg),
        .peak_bank       (peak_bank),
        .best_shift      (best_shift),
        .peak_value      (peak_value),
        .found           (found)
    );
endmodule

/* sv/pcts_datapath.sv */
// Datapath: sample and reference memories, address generation, correlation and peak tracking.
module pcts_datapath #(
    parameter int SAMPLE_DEPTH = pcts_pkg::DEF_SAMPLE_DEPTH,
    parameter int REF_DEPTH    = pcts_pkg::DEF_REF_DEPTH,
    parameter int SAMPLE_WIDTH = pcts_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pcts_pkg::pcts_cmd_t               cmd,
    output pcts_pkg::pcts_status_t            status,
    input  logic                              ref_bit,
    input  logic signed [SAMPLE_WIDTH-1:0]    sample_value,
    input  logic [pcts_pkg::GUESS_WIDTH-1:0]  start_guess,
    input  logic [4:0]                        bank_count,
    input  logic [4:0]                        samples_per_bit,
    input  logic [9:0]                        preamble_length,
    input  logic [7:0]                        search_left,
    input  logic [7:0]                        search_right,
    input  logic [7:0]                        downhill_limit,
    output logic [7:0]                        peak_bank,
    output logic signed [8:0]                 best_shift,
    output logic signed [pcts_pkg::ACC_WIDTH-1:0] peak_value,
    output logic                              found
);
    import pcts_pkg::*;

    localparam int SA_W = $clog2(SAMPLE_DEPTH);
    localparam int RA_W = $clog2(REF_DEPTH);
    localparam int SF_W = SA_W + 1;
    localparam int RF_W = RA_W + 1;
    // signed index width: guess + bank + (shift+k)*stride, generous margin
    localparam int IX_W = 28;
    // sum of up to 1023 samples, and room for the 24-bit ceiling
    localparam int SUM_W = (SAMPLE_WIDTH + 11 > ACC_WIDTH + 2) ? SAMPLE_WIDTH + 11
                                                               : ACC_WIDTH + 2;

    logic signed [SAMPLE_WIDTH-1:0] smem [SAMPLE_DEPTH];
    logic                           rmem [REF_DEPTH];

    logic [SF_W-1:0] sample_fill_reg;
    logic [RF_W-1:0] ref_fill_reg;

    logic [4:0]  banks_sat, spb_sat;
    logic [8:0]  nphase;
    logic [8:0]  bank_reg;
    logic signed [9:0] shift_reg;
    logic [9:0]  k_reg;
    logic signed [IX_W-1:0] idx_reg;     // index of current k
    logic signed [IX_W-1:0] base_reg;    // guess + bank
    logic signed [SUM_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] peak_reg, prev_reg;
    logic [8:0]  run_reg;
    logic [7:0]  best_b_reg;
    logic signed [8:0] best_s_reg;
    logic        found_reg;
    logic        abandon_reg;

    // read pipeline
    logic        rd_valid_reg, rd_use_reg;
    logic signed [SAMPLE_WIDTH-1:0] rd_data_reg;
    logic        rref_reg;

    assign banks_sat = (bank_count > 5'd16) ? 5'd16 : bank_count;
    assign spb_sat   = (samples_per_bit > 5'd16) ? 5'd16 : samples_per_bit;
    assign nphase    = 9'(banks_sat * spb_sat);

    logic in_range;
    assign in_range = (idx_reg >= 0) && (idx_reg < $signed({{(IX_W-SF_W){1'b0}}, sample_fill_reg}));
    logic ref_ok;
    assign ref_ok = ({{(32-10){1'b0}}, k_reg} < 32'(ref_fill_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample && sample_fill_reg < SF_W'(SAMPLE_DEPTH))
            smem[sample_fill_reg[SA_W-1:0]] <= sample_value;
        if (cmd.load_ref && ref_fill_reg < RF_W'(REF_DEPTH))
            rmem[ref_fill_reg[RA_W-1:0]] <= ref_bit;
        rd_data_reg <= smem[idx_reg[SA_W-1:0]];
        rref_reg    <= rmem[RA_W'(k_reg)];
    end

    logic signed [IX_W-1:0] shift_base;
    assign shift_base = base_reg + IX_W'($signed(shift_reg) * $signed({1'b0, nphase}));

    logic signed [SUM_W-1:0] ceiling;
    assign ceiling = $signed({{(SUM_W-24){1'b0}}, preamble_length, {FRAC_BITS{1'b0}}});

    logic signed [9:0] shift_nx;
    assign shift_nx = shift_reg + 10'sd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_fill_reg <= '0;
            ref_fill_reg    <= '0;
            rd_valid_reg    <= 1'b0;
            rd_use_reg      <= 1'b0;
            found_reg       <= 1'b0;
            peak_reg        <= '0;
            prev_reg        <= '0;
            run_reg         <= '0;
            best_b_reg      <= '0;
            best_s_reg      <= '0;
            abandon_reg     <= 1'b0;
            bank_reg        <= '0;
            shift_reg       <= '0;
            k_reg           <= '0;
            idx_reg         <= '0;
            base_reg        <= '0;
            acc_reg         <= '0;
        end
        else
        begin
            if (cmd.load_sample && sample_fill_reg < SF_W'(SAMPLE_DEPTH))
                sample_fill_reg <= sample_fill_reg + 1'b1;
            if (cmd.load_ref && ref_fill_reg < RF_W'(REF_DEPTH))
                ref_fill_reg <= ref_fill_reg + 1'b1;

            rd_valid_reg <= cmd.issue;
            rd_use_reg   <= in_range && ref_ok;
            if (cmd.accum && rd_valid_reg && rd_use_reg && rref_reg)
                acc_reg <= acc_reg + SUM_W'(rd_data_reg);

            if (cmd.init_search)
            begin
                peak_reg   <= '0;
                run_reg    <= '0;
                found_reg  <= 1'b0;
                best_b_reg <= '0;
                best_s_reg <= '0;
                bank_reg   <= '0;
                base_reg   <= IX_W'({1'b0, start_guess});
            end
            if (cmd.init_bank)
            begin
                prev_reg    <= '0;
                abandon_reg <= 1'b0;
                shift_reg   <= -$signed({2'b0, search_left});
            end
            if (cmd.init_corr)
            begin
                acc_reg <= '0;
                k_reg   <= '0;
                idx_reg <= shift_base;
            end
            if (cmd.issue)
            begin
                k_reg   <= k_reg + 10'd1;
                idx_reg <= idx_reg + IX_W'(nphase);
            end
            if (cmd.evaluate)
            begin
                if (acc_reg > peak_reg && acc_reg < ceiling)
                begin
                    peak_reg   <= acc_reg;
                    best_b_reg <= bank_reg[7:0];
                    best_s_reg <= shift_reg[8:0];
                    found_reg  <= 1'b1;
                end
                if (acc_reg < prev_reg)
                begin
                    run_reg <= run_reg + 9'd1;
                    if (run_reg + 9'd1 > {1'b0, downhill_limit})
                        abandon_reg <= 1'b1;
                end
                else
                    run_reg <= '0;
                prev_reg <= acc_reg;
            end
            if (cmd.next_shift)
                shift_reg <= shift_nx;
            if (cmd.next_bank)
            begin
                bank_reg <= bank_reg + 9'd1;
                base_reg <= base_reg + IX_W'(1);
            end
        end
    end

    assign status.k_last     = (k_reg == preamble_length - 10'd1);
    assign status.len_zero   = (preamble_length == 10'd0);
    assign status.shift_done = abandon_reg ||
                               (shift_reg >= $signed({2'b0, search_right}));
    assign status.bank_done  = (bank_reg >= nphase);
    assign status.none       = (nphase == 9'd0);

    assign peak_bank  = best_b_reg;
    assign best_shift = best_s_reg;
    assign peak_value = peak_reg[ACC_WIDTH-1:0];
    assign found      = found_reg;
endmodule

/* sv/pcts_ctrl.sv */
// Controller: handshake and search sequencing.
module pcts_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             opcode,
    output logic                   out_valid,
    input  logic                   out_ready,
    output pcts_pkg::pcts_cmd_t    cmd,
    input  pcts_pkg::pcts_status_t status
);
    import pcts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_BANK, S_SHIFT, S_ISSUE, S_DRAIN, S_EVAL, S_STEP, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   acc_beat;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign acc_beat  = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (acc_beat)
                begin
                    case (opcode_t'(opcode))
                        OP_LOAD_REF:    cmd.load_ref = 1'b1;
                        OP_LOAD_SAMPLE: cmd.load_sample = 1'b1;
                        OP_START:
                        begin
                            cmd.init_search = 1'b1;
                            state_next = S_BANK;
                        end
                        default: ;
                    endcase
                end
            end
            S_BANK:
            begin
                if (status.none || status.bank_done)
                    state_next = S_DONE;
                else
                begin
                    cmd.init_bank = 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (status.shift_done)
                begin
                    cmd.next_bank = 1'b1;
                    state_next = S_BANK;
                end
                else
                begin
                    cmd.init_corr = 1'b1;
                    state_next = status.len_zero ? S_EVAL : S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                cmd.issue = 1'b1;
                cmd.accum = 1'b1;
                if (status.k_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                cmd.accum = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.evaluate = 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.next_shift = 1'b1;
                state_next = S_SHIFT;
            end
            S_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

/* sv/pcts_checker.sv */
// Port-level checker for the search unit, bound to the top level.
module pcts_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic found,
    input logic signed [25:0] peak_value
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(peak_value))
        else $error("result dropped while stalled");
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
    a_found_peak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> peak_value == 26'sd0)
        else $error("peak nonzero without found");
    a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> peak_value > 26'sd0)
        else $error("found with nonpositive peak");
endmodule

bind preamble_correlation_timing_search_unit pcts_checker u_pcts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .peak_value (peak_value)
);
